[rtl/core/hnpf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hnpf_pkg
// Shared types and constants for the half neighbor pair filter: request and
// result payloads, configuration register map, field widths and resets.
// ----------------------------------------------------------------------------
package hnpf_pkg;

	// fixed field widths
	localparam int OWNER_W   = 30;
	localparam int ENTRY_W   = 32;
	localparam int COORD_W   = 32;
	localparam int COUNT_W   = 16;
	localparam int LOCAL_W   = 31;
	localparam int CUTOFF_W  = 63;
	localparam int TOL_W     = 31;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 63;

	// parameter defaults
	localparam int INDEX_BITS_DEF = 30;
	localparam int COORD_BITS_DEF = 32;

	// register reset values
	localparam logic [TOL_W-1:0]   TIE_TOL_RESET = TOL_W'(655);
	localparam logic [COUNT_W-1:0] MAX_PER_ATOM_RESET = COUNT_W'(2000);

	// configuration register map
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOCAL_COUNT    = 3'd0,
		CFG_TRICLINIC_MODE = 3'd1,
		CFG_CUTOFF_SQ      = 3'd2,
		CFG_TIE_TOLERANCE  = 3'd3,
		CFG_MAX_PER_ATOM   = 3'd4
	} cfg_reg_t;

	// one neighbor candidate
	typedef struct packed {
		logic [OWNER_W-1:0]        owner_index;
		logic [ENTRY_W-1:0]        neighbor_entry;
		logic signed [COORD_W-1:0] owner_x;
		logic signed [COORD_W-1:0] owner_y;
		logic signed [COORD_W-1:0] owner_z;
		logic signed [COORD_W-1:0] neighbor_x;
		logic signed [COORD_W-1:0] neighbor_y;
		logic signed [COORD_W-1:0] neighbor_z;
		logic                      last_in_list;
		logic                      empty_list;
	} cand_t;

	// one filter result
	typedef struct packed {
		logic               keep;
		logic [ENTRY_W-1:0] kept_entry;
		logic [COUNT_W-1:0] kept_count;
		logic               list_done;
		logic               overflow;
	} res_t;

endpackage

[rtl/core/half_neighbor_pair_filter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_neighbor_pair_filter_core
// Trims a full neighbor list to a Newton half list, one candidate per cycle when not stalled.
//
// Candidates arrive on cand/cand_valid/cand_stall, results leave on
// res/res_valid/res_stall; a request moves when valid is high and stall low.
// Every candidate, including an empty-list marker, gives exactly one result,
// in order. Five registers sit on the path (input register, ordering test,
// squaring, sum, cutoff and count). One candidate is taken per cycle while
// no stall holds the pipe; the three 32 x 32 squarers and the per-owner
// counter in the last stage do not hold it back. Stages fill bubbles
// independently, so while a finished result waits on res_stall the block
// takes up to four more candidates before cand_stall rises.
// The per-owner kept count lives in the last stage and is cleared after a
// result that closes a list. Reset empties the pipe, clears the count and
// loads register resets. Registers must be written through cfg_we/cfg_index/
// cfg_data while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module half_neighbor_pair_filter_core
	import hnpf_pkg::*;
#(
	parameter int INDEX_BITS = INDEX_BITS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cand_valid,
	output logic                  cand_stall,
	input  cand_t                 cand,
	output logic                  res_valid,
	input  logic                  res_stall,
	output res_t                  res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SQ_W  = 2 * COORD_BITS;
	localparam int SUM_W = SQ_W + 2;
	localparam int CMP_W = (SUM_W > CUTOFF_W) ? SUM_W : CUTOFF_W;

	// configuration registers
	logic [LOCAL_W-1:0]  local_count_q;
	logic                triclinic_mode_q;
	logic [CUTOFF_W-1:0] cutoff_sq_q;
	logic [TOL_W-1:0]    tie_tolerance_q;
	logic [COUNT_W-1:0]  max_per_atom_q;

	// pipeline state
	logic                  valid_s1, valid_s2, valid_s3, valid_s4;
	logic                  rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_out;
	cand_t                 cand_s1;
	logic [ENTRY_W-1:0]    entry_s2, entry_s3, entry_s4;
	logic                  last_s2, last_s3, last_s4;
	logic                  empty_s2, empty_s3, empty_s4;
	logic                  pass_s2, pass_s3, pass_s4;
	logic [COORD_BITS-1:0] mag_x_s2, mag_y_s2, mag_z_s2;
	logic [SQ_W-1:0]       sq_x_s3, sq_y_s3, sq_z_s3;
	logic [SUM_W-1:0]      rsq_s4;
	logic [COUNT_W-1:0]    count_q;
	logic                  res_valid_q;
	res_t                  res_q;

	logic                  pass_order;
	logic [COORD_BITS-1:0] mag_x, mag_y, mag_z;
	logic                  in_cutoff;
	logic                  pass_all;
	logic [COUNT_W-1:0]    count_next;
	res_t                  res_next;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_count_q    <= '0;
			triclinic_mode_q <= 1'b0;
			cutoff_sq_q      <= '0;
			tie_tolerance_q  <= TIE_TOL_RESET;
			max_per_atom_q   <= MAX_PER_ATOM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOCAL_COUNT:    local_count_q    <= cfg_data[LOCAL_W-1:0];
				CFG_TRICLINIC_MODE: triclinic_mode_q <= cfg_data[0];
				CFG_CUTOFF_SQ:      cutoff_sq_q      <= cfg_data[CUTOFF_W-1:0];
				CFG_TIE_TOLERANCE:  tie_tolerance_q  <= cfg_data[TOL_W-1:0];
				CFG_MAX_PER_ATOM:   max_per_atom_q   <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// stage ready chain, a stage loads when empty or draining
	assign rdy_out = !res_valid_q || !res_stall;
	assign rdy_s4  = !valid_s4 || rdy_out;
	assign rdy_s3  = !valid_s3 || rdy_s4;
	assign rdy_s2  = !valid_s2 || rdy_s3;
	assign rdy_s1  = !valid_s1 || rdy_s2;
	assign cand_stall = !rdy_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (rdy_s1)  valid_s1    <= cand_valid;
			if (rdy_s2)  valid_s2    <= valid_s1;
			if (rdy_s3)  valid_s3    <= valid_s2;
			if (rdy_s4)  valid_s4    <= valid_s3;
			if (rdy_out) res_valid_q <= valid_s4;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (rdy_s1 && cand_valid) begin
			cand_s1 <= cand;
		end
	end

	// ordering test and difference magnitudes
	hnpf_order #(
		.INDEX_BITS (INDEX_BITS),
		.COORD_BITS (COORD_BITS)
	) u_order (
		.cand           (cand_s1),
		.local_count    (local_count_q),
		.triclinic_mode (triclinic_mode_q),
		.tie_tolerance  (tie_tolerance_q),
		.pass_order     (pass_order),
		.mag_x          (mag_x),
		.mag_y          (mag_y),
		.mag_z          (mag_z)
	);

	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s1) begin
			entry_s2 <= cand_s1.neighbor_entry;
			last_s2  <= cand_s1.last_in_list;
			empty_s2 <= cand_s1.empty_list;
			pass_s2  <= pass_order;
			mag_x_s2 <= mag_x;
			mag_y_s2 <= mag_y;
			mag_z_s2 <= mag_z;
		end
	end

	// squares of the differences
	always_ff @(posedge clk) begin
		if (rdy_s3 && valid_s2) begin
			entry_s3 <= entry_s2;
			last_s3  <= last_s2;
			empty_s3 <= empty_s2;
			pass_s3  <= pass_s2;
			sq_x_s3  <= SQ_W'(mag_x_s2) * SQ_W'(mag_x_s2);
			sq_y_s3  <= SQ_W'(mag_y_s2) * SQ_W'(mag_y_s2);
			sq_z_s3  <= SQ_W'(mag_z_s2) * SQ_W'(mag_z_s2);
		end
	end

	// exact squared distance, wide enough that no saturation is needed
	always_ff @(posedge clk) begin
		if (rdy_s4 && valid_s3) begin
			entry_s4 <= entry_s3;
			last_s4  <= last_s3;
			empty_s4 <= empty_s3;
			pass_s4  <= pass_s3;
			rsq_s4   <= SUM_W'(sq_x_s3) + SUM_W'(sq_y_s3) + SUM_W'(sq_z_s3);
		end
	end

	// cutoff check and per-owner count
	assign in_cutoff = CMP_W'(rsq_s4) <= CMP_W'(cutoff_sq_q);
	assign pass_all  = pass_s4 && in_cutoff;

	always_comb begin
		res_next.keep       = 1'b0;
		res_next.kept_entry = entry_s4;
		res_next.list_done  = last_s4;
		res_next.overflow   = 1'b0;
		count_next          = count_q;
		if (empty_s4) begin
			res_next.kept_entry = '0;
			res_next.list_done  = 1'b1;
			count_next          = '0;
		end else if (pass_all) begin
			if (count_q >= max_per_atom_q) begin
				res_next.overflow = 1'b1;
			end else begin
				res_next.keep = 1'b1;
				count_next    = count_q + COUNT_W'(1);
			end
		end
		res_next.kept_count = count_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (rdy_out && valid_s4) begin
			count_q <= res_next.list_done ? '0 : count_next;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (rdy_out && valid_s4) begin
			res_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// a kept candidate always leaves a nonzero count
	a_keep_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.keep |-> res_q.kept_count != '0)
		else $error("kept result with zero count");

	// keep and overflow never together
	a_keep_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.keep && res_q.overflow))
		else $error("keep and overflow both set");

	// running count tracks the shown result within a list
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.list_done |-> count_q == res_q.kept_count)
		else $error("running count differs from shown count");

	// a closed list leaves the count cleared
	a_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.list_done |-> count_q == '0)
		else $error("count not cleared after end of list");

	// the last stage, holding an item with a stalled successor, keeps it
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && !rdy_out |=> valid_s4 && $stable(rsq_s4))
		else $error("last stage lost a held item");

endmodule

[rtl/core/hnpf_order.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hnpf_order
// Newton ordering test for one candidate and the coordinate difference
// magnitudes that feed the distance check.
// ----------------------------------------------------------------------------
module hnpf_order
	import hnpf_pkg::*;
#(
	parameter int INDEX_BITS = INDEX_BITS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  cand_t                  cand,
	input  logic [LOCAL_W-1:0]     local_count,
	input  logic                   triclinic_mode,
	input  logic [TOL_W-1:0]       tie_tolerance,
	output logic                   pass_order,
	output logic [COORD_BITS-1:0]  mag_x,
	output logic [COORD_BITS-1:0]  mag_y,
	output logic [COORD_BITS-1:0]  mag_z
);

	localparam int OWN_BITS = (INDEX_BITS < OWNER_W) ? INDEX_BITS : OWNER_W;
	localparam int TC_W     = (COORD_BITS > TOL_W) ? COORD_BITS + 1 : TOL_W + 1;
	localparam int IDX_CMP_W = 32;

	logic [IDX_CMP_W-1:0]   nidx;
	logic [IDX_CMP_W-1:0]   owner;
	logic                   is_local;
	logic signed [COORD_BITS:0] dx;
	logic signed [COORD_BITS:0] dy;
	logic signed [COORD_BITS:0] dz;
	logic [COORD_BITS:0]    ndx;
	logic [COORD_BITS:0]    ndy;
	logic [COORD_BITS:0]    ndz;
	logic                   far_y;
	logic                   far_z;
	logic                   ghost_pass;

	// masked indices
	assign nidx  = IDX_CMP_W'(cand.neighbor_entry[INDEX_BITS-1:0]);
	assign owner = IDX_CMP_W'(cand.owner_index[OWN_BITS-1:0]);
	assign is_local = nidx < IDX_CMP_W'(local_count);

	// exact differences, neighbor minus owner
	assign dx = $signed({cand.neighbor_x[COORD_BITS-1], cand.neighbor_x[COORD_BITS-1:0]})
		- $signed({cand.owner_x[COORD_BITS-1], cand.owner_x[COORD_BITS-1:0]});
	assign dy = $signed({cand.neighbor_y[COORD_BITS-1], cand.neighbor_y[COORD_BITS-1:0]})
		- $signed({cand.owner_y[COORD_BITS-1], cand.owner_y[COORD_BITS-1:0]});
	assign dz = $signed({cand.neighbor_z[COORD_BITS-1], cand.neighbor_z[COORD_BITS-1:0]})
		- $signed({cand.owner_z[COORD_BITS-1], cand.owner_z[COORD_BITS-1:0]});

	// magnitudes always fit in the coordinate width
	assign ndx = -dx;
	assign ndy = -dy;
	assign ndz = -dz;
	assign mag_x = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
	assign mag_y = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
	assign mag_z = dz[COORD_BITS] ? ndz[COORD_BITS-1:0] : dz[COORD_BITS-1:0];

	// axis decides when it differs (beyond the tolerance in triclinic mode)
	always_comb begin
		if (triclinic_mode) begin
			far_z = TC_W'(mag_z) > TC_W'(tie_tolerance);
			far_y = TC_W'(mag_y) > TC_W'(tie_tolerance);
		end else begin
			far_z = dz != '0;
			far_y = dy != '0;
		end
	end

	// ghost above and to the right of the owner
	always_comb begin
		if (far_z) begin
			ghost_pass = !dz[COORD_BITS];
		end else if (far_y) begin
			ghost_pass = !dy[COORD_BITS];
		end else begin
			ghost_pass = !dx[COORD_BITS];
		end
	end

	assign pass_order = is_local ? (owner <= nidx) : ghost_pass;

endmodule
